// ===== sv/bmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

    // matrix and window limits
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int MAX_RADIUS = 15;

    // field widths
    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int SAMPLE_W = 16;
    localparam int SIZE_W   = 7;
    localparam int RAD_W    = 5;
    localparam int RADU_W   = $clog2(MAX_RADIUS + 1);

    // accumulator and divider widths
    localparam int COUNT_W = 10;
    localparam int SUM_W   = 26;
    localparam int NUM_W   = 26;
    localparam int DEN_W   = COUNT_W + 1;
    localparam int STEP_W  = $clog2(NUM_W);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT    = 2'd0,
        CFG_COLUMN_COUNT = 2'd1,
        CFG_RADIUS       = 2'd2
    } cfg_index_t;

    // input function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== sv/bmf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_in_if / bmf_out_if
// Valid/ready channels for filter requests and filter results.
// ----------------------------------------------------------------------------
interface bmf_in_if;
    import bmf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output func, output row, output col, output sample,
                    input ready);
    modport sink   (input valid, input func, input row, input col, input sample,
                    output ready);
endinterface

interface bmf_out_if;
    import bmf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mean_value;
    logic                       error;

    modport source (output valid, output mean_value, output error, input ready);
    modport sink   (input valid, input mean_value, input error, output ready);
endinterface

// ===== sv/bmf_sample_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_sample_ram
// Sample matrix storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bmf_sample_ram
(
    input  logic                                clk,
    input  logic                                we,
    input  logic [bmf_pkg::ADDR_W-1:0]          waddr,
    input  logic [bmf_pkg::SAMPLE_W-1:0]        wdata,
    input  logic [bmf_pkg::ADDR_W-1:0]          raddr,
    output logic [bmf_pkg::SAMPLE_W-1:0]        rdata
);
    import bmf_pkg::*;

    logic [SAMPLE_W-1:0] mem [MAX_ROWS*MAX_COLS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/bmf_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_divider
// Restoring divider, one quotient bit per cycle, done pulse when finished.
// ----------------------------------------------------------------------------
module bmf_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bmf_pkg::NUM_W-1:0]     num,
    input  logic [bmf_pkg::DEN_W-1:0]     den,
    output logic                          done,
    output logic [bmf_pkg::NUM_W-1:0]     quotient
);
    import bmf_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;

    logic [DEN_W:0]    trial;
    logic              fits;
    logic [DEN_W:0]    trial_sub;

    // one compare and subtract per step
    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        fits      = trial >= {1'b0, den_reg};
        trial_sub = trial - {1'b0, den_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/box_mean_filter_2d.sv =====
`timescale 1ns / 1ps
// Operation: a sample write gives no result. A query reads its window from
// memory, one memory read per cycle, N being the number of in-bounds window
// samples (up to 961), then runs a serial divide; an error query skips both.
// One item at a time; ready is low while a query runs.
// Reset sets row_count, column_count and radius to 1; sample memory is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// box_mean_filter_2d
// Stored Q8.8 matrix with a clipped square-window mean query.
// ----------------------------------------------------------------------------
module box_mean_filter_2d
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]      cfg_data,
    bmf_in_if.sink                              in_ch,
    bmf_out_if.source                           out_ch
);
    import bmf_pkg::*;

    state_t                     state_reg,  state_next;
    logic [SIZE_W-1:0]          row_count_reg;
    logic [SIZE_W-1:0]          column_count_reg;
    logic signed [RAD_W-1:0]    radius_reg;
    logic [ROW_W-1:0]           i_reg,      i_next;
    logic [COL_W-1:0]           j_reg,      j_next;
    logic [ROW_W-1:0]           r1_reg,     r1_next;
    logic [COL_W-1:0]           c0_reg,     c0_next;
    logic [COL_W-1:0]           c1_reg,     c1_next;
    logic                       err_reg,    err_next;
    logic                       rd_valid_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [COUNT_W-1:0]         count_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_mean_reg;
    logic                       out_error_reg;

    logic                       accept;
    logic [SIZE_W-1:0]          rows_eff;
    logic [SIZE_W-1:0]          cols_eff;
    logic                       in_bounds;
    logic [RADU_W-1:0]          rad;
    logic [ROW_W:0]             row_lo, row_hi, row_top;
    logic [COL_W:0]             col_lo, col_hi, col_top;
    logic                       clear_acc;
    logic                       out_load;
    logic                       ram_we;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic                       sum_neg;
    logic [SUM_W-1:0]           sum_mag;
    logic [NUM_W-1:0]           div_num;
    logic [DEN_W-1:0]           div_den;
    logic                       div_start;
    logic                       div_done;
    logic [NUM_W-1:0]           div_quo;
    logic signed [SAMPLE_W-1:0] mean_signed;

    // handshake
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // effective size, window bounds
    always_comb
    begin
        rows_eff  = (row_count_reg > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : row_count_reg;
        cols_eff  = (column_count_reg > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS)
                                                            : column_count_reg;
        in_bounds = ({1'b0, in_ch.row} < rows_eff) && ({1'b0, in_ch.col} < cols_eff);
        rad       = (radius_reg > RAD_W'(MAX_RADIUS)) ? RADU_W'(MAX_RADIUS)
                                                      : RADU_W'(radius_reg);
        row_lo    = {1'b0, in_ch.row} - (ROW_W+1)'(rad);
        col_lo    = {1'b0, in_ch.col} - (COL_W+1)'(rad);
        row_hi    = {1'b0, in_ch.row} + (ROW_W+1)'(rad);
        col_hi    = {1'b0, in_ch.col} + (COL_W+1)'(rad);
        row_top   = (ROW_W+1)'(rows_eff - 1'b1);
        col_top   = (COL_W+1)'(cols_eff - 1'b1);
    end

    // in-bounds sample writes go straight to memory
    assign ram_we = accept && (in_ch.func == FUNC_WRITE) && in_bounds;

    bmf_sample_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({in_ch.row, in_ch.col}),
        .wdata (in_ch.sample),
        .raddr ({i_reg, j_reg}),
        .rdata (ram_rdata)
    );

    // divider operands: (2|sum| + n) / 2n gives round half away from zero
    always_comb
    begin
        sum_neg = sum_reg[SUM_W-1];
        sum_mag = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        div_num = (NUM_W'(sum_mag) << 1) + NUM_W'(count_reg);
        div_den = {count_reg, 1'b0};
    end

    assign div_start = (state_reg == ST_START);

    bmf_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign mean_signed = sum_neg ? SAMPLE_W'(-div_quo[SAMPLE_W-1:0])
                                 : SAMPLE_W'(div_quo[SAMPLE_W-1:0]);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        r1_next    = r1_reg;
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        err_next   = err_reg;
        clear_acc  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_ch.func == FUNC_QUERY))
                begin
                    clear_acc = 1'b1;
                    if (radius_reg[RAD_W-1] || !in_bounds)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        i_next     = row_lo[ROW_W] ? '0 : row_lo[ROW_W-1:0];
                        j_next     = col_lo[COL_W] ? '0 : col_lo[COL_W-1:0];
                        c0_next    = col_lo[COL_W] ? '0 : col_lo[COL_W-1:0];
                        r1_next    = (row_hi > row_top) ? row_top[ROW_W-1:0]
                                                        : row_hi[ROW_W-1:0];
                        c1_next    = (col_hi > col_top) ? col_top[COL_W-1:0]
                                                        : col_hi[COL_W-1:0];
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (j_reg == c1_reg)
                begin
                    j_next = c0_reg;
                    if (i_reg == r1_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            row_count_reg    <= SIZE_W'(1);
            column_count_reg <= SIZE_W'(1);
            radius_reg       <= RAD_W'(1);
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_WALK);
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_ROW_COUNT:    row_count_reg    <= cfg_data[SIZE_W-1:0];
                    CFG_COLUMN_COUNT: column_count_reg <= cfg_data[SIZE_W-1:0];
                    CFG_RADIUS:       radius_reg       <= cfg_data[RAD_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // window walk and accumulation
    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        r1_reg  <= r1_next;
        c0_reg  <= c0_next;
        c1_reg  <= c1_next;
        err_reg <= err_next;
        if (clear_acc)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            sum_reg   <= sum_reg + SUM_W'($signed(ram_rdata));
            count_reg <= count_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_mean_reg  <= err_reg ? '0 : mean_signed;
            out_error_reg <= err_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.mean_value = out_mean_reg;
    assign out_ch.error      = out_error_reg;

endmodule
